// ===== hw/rtl/jet_pkg.sv =====
// ----------------------------------------------------------------------------
// jet_pkg
// Shared widths, register indexes and reset values of the Julia-set
// escape-time pixel evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package jet_pkg;

  // Default parameter values
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 28;

  // Shared multiplier: chunk width and default chunk count per operand
  localparam int MUL_CHUNK   = 32;
  localparam int MUL_NCH_DEF = 1;

  // Register and field widths
  localparam int CREG_W     = 32;  // c_re, c_im, Q4.28
  localparam int C_FRAC     = 28;  // fraction bits of c registers
  localparam int ZOOM_W     = 31;  // zoom, Q7.24
  localparam int ZOOM_FRAC  = 24;  // fraction bits of zoom
  localparam int ITER_W     = 16;  // iteration limit and count
  localparam int SIZE_W     = 13;  // frame width / height
  localparam int GRAY_W     = 8;   // gray level
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C_RE         = 3'd0,
    REG_C_IM         = 3'd1,
    REG_ZOOM         = 3'd2,
    REG_MAX_ITER     = 3'd3,
    REG_FRAME_WIDTH  = 3'd4,
    REG_FRAME_HEIGHT = 3'd5
  } cfg_reg_t;

  // Reset values
  localparam logic [CREG_W-1:0] C_RE_RST     = CREG_W'(-214748365);  // -0.8
  localparam logic [CREG_W-1:0] C_IM_RST     = CREG_W'(41875931);    // 0.156
  localparam logic [ZOOM_W-1:0] ZOOM_RST     = ZOOM_W'(10905190);    // 0.65
  localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(500);
  localparam logic [SIZE_W-1:0] FRAME_W_RST  = SIZE_W'(1600);
  localparam logic [SIZE_W-1:0] FRAME_H_RST  = SIZE_W'(900);

endpackage

`default_nettype wire

// ===== hw/rtl/jet_pix_if.sv =====
// ----------------------------------------------------------------------------
// jet_pix_if
// Pixel coordinate channel: valid/ready with column and row payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface jet_pix_if #(
  parameter int COORD_BITS = jet_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_col;
  logic [COORD_BITS-1:0] pixel_row;

  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/jet_res_if.sv =====
// ----------------------------------------------------------------------------
// jet_res_if
// Result channel: valid/ready with escape count, gray level and escape flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface jet_res_if;
  import jet_pkg::*;

  logic              valid;
  logic              ready;
  logic [ITER_W-1:0] escape_count;
  logic [GRAY_W-1:0] gray_level;
  logic              escaped;

  modport source (output valid, output escape_count, output gray_level, output escaped,
                  input ready);
  modport sink   (input valid, input escape_count, input gray_level, input escaped,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/jet_cfg_if.sv =====
// ----------------------------------------------------------------------------
// jet_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface jet_cfg_if;
  import jet_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/julia_escape_time_pixel.sv =====
// ----------------------------------------------------------------------------
// julia_escape_time_pixel
// Sequence: per axis a size*zoom multiply and a long division map the pixel
//   to the start point; each iteration squares both z components, tests for
//   escape, forms the cross product and updates z; a final division forms the
//   gray level.
// Throughput: one pixel at a time; the 32x32 multiplier, used for every
//   product in sequence, sets the iteration time.
// Reset: configuration registers take their default values, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module julia_escape_time_pixel #(
  parameter int COORD_BITS = jet_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = jet_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  jet_pix_if.sink   pixel,
  jet_res_if.source result,
  jet_cfg_if.sink   cfg
);
  import jet_pkg::*;

  localparam int ZW     = FRAC_BITS + 4;   // signed z component
  localparam int QW     = FRAC_BITS + 3;   // z magnitude
  localparam int SQW    = FRAC_BITS + 6;   // truncated square
  localparam int XW     = FRAC_BITS + 7;   // cross product magnitude
  localparam int MW     = FRAC_BITS + 7;   // |z|^2
  localparam int NRW    = FRAC_BITS + 9;   // update sums before saturation
  localparam int OPW    = (ZW > ZOOM_W) ? ZW : ZOOM_W;
  localparam int NCH    = (OPW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int OW     = NCH * MUL_CHUNK;
  localparam int AW     = 2 * OW;
  localparam int DW     = SIZE_W + ZOOM_W;
  localparam int NB     = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W;
  localparam int DSTEPS = NB + FRAC_BITS + ZOOM_FRAC;
  localparam int STW    = $clog2(DSTEPS);
  localparam int GSW    = $clog2(GRAY_W);
  localparam int GNW    = ITER_W + GRAY_W;

  localparam logic [ZW-1:0]  ZMAX    = {1'b0, {QW{1'b1}}};
  localparam logic [ZW-1:0]  ZMIN    = ~ZMAX + ZW'(1);
  localparam logic [NRW-1:0] SAT_HI  = NRW'(ZMAX);
  localparam logic [NRW-1:0] SAT_LO  = ~SAT_HI + NRW'(1);
  localparam logic [MW-1:0]  FOUR    = MW'(4) << FRAC_BITS;
  localparam logic [MW-1:0]  SIXTEEN = MW'(16) << FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_MUL,
    S_MAP_DIV,
    S_SQ_R,
    S_SQ_I,
    S_CHECK,
    S_CROSS,
    S_UPDATE,
    S_GRAY,
    S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [CREG_W-1:0] c_re;
  logic [CREG_W-1:0] c_im;
  logic [ZOOM_W-1:0] zoom;
  logic [ITER_W-1:0] max_it;
  logic [SIZE_W-1:0] frame_w;
  logic [SIZE_W-1:0] frame_h;

  // pixel and coordinate mapping
  logic [COORD_BITS-1:0] col_r;
  logic [COORD_BITS-1:0] row_r;
  logic                  axis;
  logic [DW-1:0]         d_r;
  logic [DW-1:0]         rem;
  logic [NB-1:0]         n_sh;
  logic [QW-1:0]         q;
  logic                  ovf;
  logic [STW-1:0]        dstep;

  // iteration
  logic [ZW-1:0]     zr;
  logic [ZW-1:0]     zi;
  logic [SQW-1:0]    sq_r;
  logic [SQW-1:0]    sq_i;
  logic [XW:0]       xprod;
  logic [ITER_W-1:0] iter;

  // shared multiplier
  logic          mul_start;
  logic [OW-1:0] mul_a;
  logic [OW-1:0] mul_b;
  logic          mul_done;
  logic [AW-1:0] mul_prod;

  // count and gray division
  logic [ITER_W-1:0] count_r;
  logic              esc_r;
  logic [GNW-1:0]    gr;
  logic [GNW-2:0]    gd;
  logic [GRAY_W-1:0] gq;
  logic [GSW-1:0]    gstep;

  // output register
  logic              res_valid;
  logic [ITER_W-1:0] res_count;
  logic [GRAY_W-1:0] res_gray;
  logic              res_esc;

  // combinational helpers
  logic [COORD_BITS-1:0] coord_sel;
  logic [SIZE_W-1:0]     size_sel;
  logic [NB:0]           num;
  logic [NB:0]           num_abs;
  logic                  num_neg;
  logic [NB-1:0]         n_mag;
  logic [DW-1:0]         d_prod;
  logic [DW:0]           rem2;
  logic [DW:0]           rem_nx;
  logic                  div_ge;
  logic [QW-1:0]         q_nx;
  logic                  ovf_nx;
  logic                  div_last;
  logic                  map_fin;
  logic [QW-1:0]         map_mag;
  logic [ZW-1:0]         map_ext;
  logic [ZW-1:0]         map_z;
  logic [ZW-1:0]         zr_abs;
  logic [ZW-1:0]         zi_abs;
  logic [ZW-1:0]         zr2_abs;
  logic [CREG_W+FRAC_BITS-1:0] cr_wide;
  logic [CREG_W+FRAC_BITS-1:0] ci_wide;
  logic [ZW-1:0]         cr;
  logic [ZW-1:0]         ci;
  logic [NRW-1:0]        nr;
  logic [NRW-1:0]        ni;
  logic [ZW-1:0]         zr_nx;
  logic [ZW-1:0]         zi_nx;
  logic [ZW-1:0]         zr_nx_abs;
  logic [XW-1:0]         x_mag;
  logic                  x_neg;
  logic [MW-1:0]         m;
  logic                  go_on;
  logic [ITER_W-1:0]     adj;
  logic [ITER_W-1:0]     cnt;
  logic                  g_ge;

  // coordinate mapping: sign and magnitude of 2*coord - size
  always_comb begin
    coord_sel = axis ? row_r : col_r;
    size_sel  = axis ? frame_h : frame_w;
    num       = (NB+1)'({coord_sel, 1'b0}) - (NB+1)'(size_sel);
    num_neg   = num[NB];
    num_abs   = num_neg ? (~num + (NB+1)'(1)) : num;
    n_mag     = num_abs[NB-1:0];
    d_prod    = mul_prod[DW-1:0];
  end

  // one restoring division step per cycle, quotient saturates on overflow
  always_comb begin
    rem2     = {rem, n_sh[NB-1]};
    div_ge   = rem2 >= {1'b0, d_r};
    rem_nx   = div_ge ? (rem2 - {1'b0, d_r}) : rem2;
    q_nx     = {q[QW-2:0], div_ge};
    ovf_nx   = ovf | q[QW-1];
    div_last = (dstep == STW'(DSTEPS - 1));
  end

  // end of mapping for the current axis: zero numerator, zero divisor or
  // last division step
  always_comb begin
    map_fin = 1'b0;
    map_mag = '0;
    if (state == S_MAP_MUL && mul_done && (n_mag == '0 || d_prod == '0)) begin
      map_fin = 1'b1;
      map_mag = (n_mag == '0) ? '0 : ZMAX[QW-1:0];
    end else if (state == S_MAP_DIV && div_last) begin
      map_fin = 1'b1;
      map_mag = ovf_nx ? ZMAX[QW-1:0] : q_nx;
    end
    map_ext = {1'b0, map_mag};
    map_z   = num_neg ? (~map_ext + ZW'(1)) : map_ext;
  end

  // z update: rescaled constant, sums, saturation
  always_comb begin
    zr_abs    = zr[ZW-1] ? (~zr + ZW'(1)) : zr;
    zi_abs    = zi[ZW-1] ? (~zi + ZW'(1)) : zi;
    zr2_abs   = {zr_abs[ZW-2:0], 1'b0};
    cr_wide   = {c_re, {FRAC_BITS{1'b0}}};
    ci_wide   = {c_im, {FRAC_BITS{1'b0}}};
    cr        = cr_wide[CREG_W+FRAC_BITS-1:C_FRAC];
    ci        = ci_wide[CREG_W+FRAC_BITS-1:C_FRAC];
    nr        = NRW'(sq_r) - NRW'(sq_i) + {{(NRW-ZW){cr[ZW-1]}}, cr};
    ni        = {xprod[XW], xprod} + {{(NRW-ZW){ci[ZW-1]}}, ci};
    if ($signed(nr) > $signed(SAT_HI)) begin
      zr_nx = ZMAX;
    end else if ($signed(nr) < $signed(SAT_LO)) begin
      zr_nx = ZMIN;
    end else begin
      zr_nx = nr[ZW-1:0];
    end
    if ($signed(ni) > $signed(SAT_HI)) begin
      zi_nx = ZMAX;
    end else if ($signed(ni) < $signed(SAT_LO)) begin
      zi_nx = ZMIN;
    end else begin
      zi_nx = ni[ZW-1:0];
    end
    zr_nx_abs = zr_nx[ZW-1] ? (~zr_nx + ZW'(1)) : zr_nx;
    x_mag     = mul_prod[FRAC_BITS+XW-1:FRAC_BITS];
    x_neg     = zr[ZW-1] ^ zi[ZW-1];
  end

  // escape test, smoothed count and gray division step
  always_comb begin
    m     = MW'(sq_r) + MW'(sq_i);
    go_on = (iter < max_it) && (m < FOUR);
    if (m > SIXTEEN) begin
      adj = ITER_W'(2);
    end else if (m > FOUR) begin
      adj = ITER_W'(1);
    end else begin
      adj = '0;
    end
    cnt  = (iter < adj) ? '0 : (iter - adj);
    g_ge = gr >= GNW'(gd);
  end

  // sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mul_start <= 1'b0;
      res_valid <= 1'b0;
      axis      <= 1'b0;
      c_re      <= C_RE_RST;
      c_im      <= C_IM_RST;
      zoom      <= ZOOM_RST;
      max_it    <= MAX_ITER_RST;
      frame_w   <= FRAME_W_RST;
      frame_h   <= FRAME_H_RST;
    end else begin
      mul_start <= 1'b0;
      if (result.ready) begin
        res_valid <= 1'b0;
      end

      // configuration write
      if (cfg.valid) begin
        case (cfg_reg_t'(cfg.index))
          REG_C_RE:         c_re    <= cfg.data;
          REG_C_IM:         c_im    <= cfg.data;
          REG_ZOOM:         zoom    <= cfg.data[ZOOM_W-1:0];
          REG_MAX_ITER:     max_it  <= cfg.data[ITER_W-1:0];
          REG_FRAME_WIDTH:  frame_w <= cfg.data[SIZE_W-1:0];
          REG_FRAME_HEIGHT: frame_h <= cfg.data[SIZE_W-1:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (pixel.valid) begin
            col_r     <= pixel.pixel_col;
            row_r     <= pixel.pixel_row;
            axis      <= 1'b0;
            mul_a     <= OW'(frame_w);
            mul_b     <= OW'(zoom);
            mul_start <= 1'b1;
            state     <= S_MAP_MUL;
          end
        end
        S_MAP_MUL: begin
          // divisor size*zoom ready; start the long division
          if (mul_done) begin
            d_r   <= d_prod;
            rem   <= '0;
            q     <= '0;
            ovf   <= 1'b0;
            dstep <= '0;
            n_sh  <= n_mag;
            state <= S_MAP_DIV;
          end
        end
        S_MAP_DIV: begin
          rem   <= rem_nx[DW-1:0];
          q     <= q_nx;
          ovf   <= ovf_nx;
          n_sh  <= {n_sh[NB-2:0], 1'b0};
          dstep <= dstep + 1'b1;
        end
        S_SQ_R: begin
          if (mul_done) begin
            sq_r      <= mul_prod[FRAC_BITS+SQW-1:FRAC_BITS];
            mul_a     <= OW'(zi_abs);
            mul_b     <= OW'(zi_abs);
            mul_start <= 1'b1;
            state     <= S_SQ_I;
          end
        end
        S_SQ_I: begin
          if (mul_done) begin
            sq_i  <= mul_prod[FRAC_BITS+SQW-1:FRAC_BITS];
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (go_on) begin
            mul_a     <= OW'(zr2_abs);
            mul_b     <= OW'(zi_abs);
            mul_start <= 1'b1;
            state     <= S_CROSS;
          end else begin
            count_r <= cnt;
            esc_r   <= (m >= FOUR);
            gr      <= {cnt, {GRAY_W{1'b0}}} - GNW'(cnt);
            gd      <= {max_it, {(GRAY_W-1){1'b0}}};
            gq      <= '0;
            gstep   <= '0;
            state   <= S_GRAY;
          end
        end
        S_CROSS: begin
          if (mul_done) begin
            xprod <= x_neg ? (~{1'b0, x_mag} + (XW+1)'(1)) : {1'b0, x_mag};
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          zr        <= zr_nx;
          zi        <= zi_nx;
          iter      <= iter + 1'b1;
          mul_a     <= OW'(zr_nx_abs);
          mul_b     <= OW'(zr_nx_abs);
          mul_start <= 1'b1;
          state     <= S_SQ_R;
        end
        S_GRAY: begin
          // count*255 / max_iterations, one quotient bit a cycle
          if (g_ge) begin
            gr <= gr - GNW'(gd);
          end
          gq    <= {gq[GRAY_W-2:0], g_ge};
          gd    <= gd >> 1;
          gstep <= gstep + 1'b1;
          if (gstep == GSW'(GRAY_W - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            res_count <= count_r;
            res_gray  <= (max_it == '0) ? '0 : gq;
            res_esc   <= esc_r;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // store the mapped component; move on to the other axis or iterate
      if (map_fin) begin
        if (!axis) begin
          zr        <= map_z;
          axis      <= 1'b1;
          mul_a     <= OW'(frame_h);
          mul_b     <= OW'(zoom);
          mul_start <= 1'b1;
          state     <= S_MAP_MUL;
        end else begin
          zi        <= map_z;
          iter      <= '0;
          mul_a     <= OW'(zr_abs);
          mul_b     <= OW'(zr_abs);
          mul_start <= 1'b1;
          state     <= S_SQ_R;
        end
      end
    end
  end

  jet_mul #(
    .NCH (NCH)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // channel outputs
  assign pixel.ready         = (state == S_IDLE);
  assign cfg.ready           = 1'b1;
  assign result.valid        = res_valid;
  assign result.escape_count = res_count;
  assign result.gray_level   = res_gray;
  assign result.escaped      = res_esc;

endmodule

`default_nettype wire

// ===== hw/rtl/jet_mul.sv =====
// ----------------------------------------------------------------------------
// jet_mul
// Shared unsigned multiplier. Operands are split into MUL_CHUNK-bit chunks;
// one chunk product is formed per cycle and summed into a double-width
// accumulator. done pulses one cycle with prod final.
// ----------------------------------------------------------------------------
`default_nettype none

module jet_mul #(
  parameter int NCH = jet_pkg::MUL_NCH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [NCH*jet_pkg::MUL_CHUNK-1:0]   a,
  input  logic [NCH*jet_pkg::MUL_CHUNK-1:0]   b,
  output logic                                done,
  output logic [2*NCH*jet_pkg::MUL_CHUNK-1:0] prod
);
  import jet_pkg::*;

  localparam int OW = NCH * MUL_CHUNK;
  localparam int AW = 2 * OW;
  localparam int IW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PW = $clog2(2 * NCH);

  logic [OW-1:0]          a_r;
  logic [OW-1:0]          b_r;
  logic                   busy;
  logic [IW-1:0]          ia;
  logic [IW-1:0]          ib;
  logic [MUL_CHUNK-1:0]   a_ck;
  logic [MUL_CHUNK-1:0]   b_ck;
  logic                   last_issue;
  logic [2*MUL_CHUNK-1:0] pp;
  logic [PW-1:0]          pp_pos;
  logic                   pp_vld;
  logic                   pp_last;
  logic [AW-1:0]          acc;
  logic                   done_r;

  // chunk select for the current partial product
  always_comb begin
    a_ck       = a_r[ia*MUL_CHUNK +: MUL_CHUNK];
    b_ck       = b_r[ib*MUL_CHUNK +: MUL_CHUNK];
    last_issue = (ia == IW'(NCH - 1)) && (ib == IW'(NCH - 1));
  end

  // partial product register
  always_ff @(posedge clk) begin
    pp      <= a_ck * b_ck;
    pp_pos  <= PW'(ia) + PW'(ib);
    pp_last <= last_issue;
  end

  // chunk sequencer and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      pp_vld <= 1'b0;
      done_r <= 1'b0;
    end else begin
      pp_vld <= busy;
      done_r <= pp_vld & pp_last;
      if (pp_vld) begin
        acc <= acc + (AW'(pp) << (pp_pos * MUL_CHUNK));
      end
      if (start) begin
        a_r  <= a;
        b_r  <= b;
        ia   <= '0;
        ib   <= '0;
        acc  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (last_issue) begin
          busy <= 1'b0;
        end else if (ib == IW'(NCH - 1)) begin
          ib <= '0;
          ia <= ia + 1'b1;
        end else begin
          ib <= ib + 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc;

endmodule

`default_nettype wire
